### rtl/integer_alu_32_macros.svh
// assertion macros for the integer alu
`ifndef INTEGER_ALU_32_MACROS_SVH
`define INTEGER_ALU_32_MACROS_SVH
// implication checked on every clock edge outside reset
`define IA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication outside reset
`define IA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/ia32_pkg.sv
// shared operation codes and types for the integer alu
`default_nettype none
package ia32_pkg;
    localparam int ModeW = 5;
    localparam logic [ModeW-1:0] OP_ZERO = 5'd0;
    localparam logic [ModeW-1:0] OP_ADD  = 5'd1;
    localparam logic [ModeW-1:0] OP_SUB  = 5'd2;
    localparam logic [ModeW-1:0] OP_MUL  = 5'd3;
    localparam logic [ModeW-1:0] OP_DIVS = 5'd4;
    localparam logic [ModeW-1:0] OP_DIVU = 5'd5;
    localparam logic [ModeW-1:0] OP_REMS = 5'd6;
    localparam logic [ModeW-1:0] OP_REMU = 5'd7;
    localparam logic [ModeW-1:0] OP_SHL  = 5'd8;
    localparam logic [ModeW-1:0] OP_SRA  = 5'd9;
    localparam logic [ModeW-1:0] OP_SRL  = 5'd10;
    localparam logic [ModeW-1:0] OP_OR   = 5'd11;
    localparam logic [ModeW-1:0] OP_XOR  = 5'd12;
    localparam logic [ModeW-1:0] OP_AND  = 5'd13;
    localparam logic [ModeW-1:0] OP_SLTS = 5'd14;
    localparam logic [ModeW-1:0] OP_SLTU = 5'd15;
    localparam logic [ModeW-1:0] OP_CMP  = 5'd16;
    localparam int ShamtW = 5;

    // class of unit that carries out an operation
    typedef enum logic [1:0] {
        T_CLS_SIMPLE = 2'd0,
        T_CLS_MUL    = 2'd1,
        T_CLS_DIV    = 2'd2
    } t_cls;
endpackage
`default_nettype wire

### rtl/ia32_front.sv
// front end: decodes an operation and does the simple ones
`default_nettype none
module ia32_front #(
    parameter int WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [ia32_pkg::ModeW-1:0]   i_mode,
    input  wire logic [WIDTH-1:0]             i_left,
    input  wire logic [WIDTH-1:0]             i_right,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output ia32_pkg::t_cls                    o_cls,
    output logic [ia32_pkg::ModeW-1:0]        o_mode,
    output logic [WIDTH-1:0]                  o_left,
    output logic [WIDTH-1:0]                  o_right,
    output logic [WIDTH-1:0]                  o_simple
);
    import ia32_pkg::*;

    logic                r_valid;
    t_cls                r_cls;
    logic [ModeW-1:0]    r_mode;
    logic [WIDTH-1:0]    r_left, r_right, r_simple;
    t_cls                n_cls;
    logic [WIDTH-1:0]    n_simple;
    logic [ShamtW-1:0]   shamt;
    logic                lt_s, lt_u, eq;
    logic                load;

    assign shamt = i_right[ShamtW-1:0];
    assign lt_u  = i_left < i_right;
    assign lt_s  = $signed(i_left) < $signed(i_right);
    assign eq    = i_left == i_right;

    always_comb begin
        n_cls    = T_CLS_SIMPLE;
        n_simple = '0;
        unique case (i_mode)
            OP_ADD:  n_simple = i_left + i_right;
            OP_SUB:  n_simple = i_left - i_right;
            OP_MUL:  n_cls = T_CLS_MUL;
            OP_DIVS, OP_DIVU, OP_REMS, OP_REMU: n_cls = T_CLS_DIV;
            OP_SHL:  n_simple = i_left << shamt;
            OP_SRA:  n_simple = WIDTH'($signed(i_left) >>> shamt);
            OP_SRL:  n_simple = i_left >> shamt;
            OP_OR:   n_simple = i_left | i_right;
            OP_XOR:  n_simple = i_left ^ i_right;
            OP_AND:  n_simple = i_left & i_right;
            OP_SLTS: n_simple = WIDTH'(lt_s);
            OP_SLTU: n_simple = WIDTH'(lt_u);
            OP_CMP:  n_simple = WIDTH'({~lt_u, ~lt_s, eq});
            default: n_simple = '0;
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (load) begin
            r_cls    <= n_cls;
            r_mode   <= i_mode;
            r_left   <= i_left;
            r_right  <= i_right;
            r_simple <= n_simple;
        end
    end

    assign o_valid  = r_valid;
    assign o_cls    = r_cls;
    assign o_mode   = r_mode;
    assign o_left   = r_left;
    assign o_right  = r_right;
    assign o_simple = r_simple;
endmodule
`default_nettype wire

### rtl/ia32_queue.sv
// short fifo that decouples the front and back ends
`default_nettype none
`include "integer_alu_32_macros.svh"
module ia32_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [DW-1:0] i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [DW-1:0]      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DW-1:0]  r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           wr, rd;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end

    `IA_ASSERT_IMP(a_q_bound, i_clk, i_rst_n, 1'b1, r_cnt <= (AW+1)'(DEPTH))
    `IA_ASSERT_NXT(a_q_fill, i_clk, i_rst_n, wr && !rd, r_cnt == $past(r_cnt) + 1'b1)
    `IA_ASSERT_NXT(a_q_drain, i_clk, i_rst_n, rd && !wr, r_cnt == $past(r_cnt) - 1'b1)
endmodule
`default_nettype wire

### rtl/ia32_back.sv
// back end: pipelined multiply and radix-2 divide with an in-order result stage
`default_nettype none
`include "integer_alu_32_macros.svh"
module ia32_back #(
    parameter int WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire ia32_pkg::t_cls               i_cls,
    input  wire logic [ia32_pkg::ModeW-1:0]   i_mode,
    input  wire logic [WIDTH-1:0]             i_left,
    input  wire logic [WIDTH-1:0]             i_right,
    input  wire logic [WIDTH-1:0]             i_simple,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [WIDTH-1:0]                  o_result
);
    import ia32_pkg::*;

    // pipeline: stage 0 operand prep, WIDTH divide steps, copy stage, then fixup
    localparam int NS = WIDTH + 2;
    localparam int HW = (WIDTH + 1) / 2;

    logic             r_v   [NS];
    t_cls             r_cls [NS];
    logic [ModeW-1:0] r_md  [NS];
    logic [WIDTH-1:0] r_a   [NS];   // simple result / dividend shifting / quotient
    logic [WIDTH-1:0] r_b   [NS];   // divisor magnitude or right multiply operand
    logic [WIDTH-1:0] r_rm  [NS];   // partial remainder
    logic             r_nq  [NS];
    logic             r_nr  [NS];
    logic             r_dz  [NS];
    logic [WIDTH-1:0] r_l   [NS];   // raw dividend
    logic [2*WIDTH-1:0] r_p0 [NS];  // multiply partial sum

    logic             adv;
    logic             sgn, neg_l, neg_r;
    logic [WIDTH-1:0] mag_l, mag_r;
    logic [WIDTH-1:0] r_res;
    logic             r_ov;

    assign adv     = !r_ov || i_ready;
    assign o_ready = adv;
    assign o_valid = r_ov;
    assign o_result = r_res;

    assign sgn   = (i_mode == OP_DIVS) || (i_mode == OP_REMS);
    assign neg_l = sgn && i_left[WIDTH-1];
    assign neg_r = sgn && i_right[WIDTH-1];
    assign mag_l = neg_l ? -i_left : i_left;
    assign mag_r = neg_r ? -i_right : i_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) r_v[k] <= r_v[k-1];
            r_ov <= r_v[NS-1];
        end
        if (adv) begin
            // stage 0: low partial product of the multiply, divide operand prep
            r_cls[0] <= i_cls;
            r_md[0]  <= i_mode;
            r_a[0]   <= (i_cls == T_CLS_DIV) ? mag_l : i_simple;
            r_b[0]   <= (i_cls == T_CLS_MUL) ? i_right : mag_r;
            r_rm[0]  <= '0;
            r_nq[0]  <= neg_l ^ neg_r;
            r_nr[0]  <= neg_l;
            r_dz[0]  <= i_right == '0;
            r_l[0]   <= i_left;
            r_p0[0]  <= (2*WIDTH)'(i_left) * (2*WIDTH)'(i_right[HW-1:0]);
            // one restoring divide step per stage
            for (int k = 1; k <= WIDTH; k++) begin
                logic [WIDTH:0] tr;
                logic [WIDTH:0] df;
                tr = {r_rm[k-1], r_a[k-1][WIDTH-1]};
                df = tr - {1'b0, r_b[k-1]};
                r_cls[k] <= r_cls[k-1];
                r_md[k]  <= r_md[k-1];
                r_b[k]   <= r_b[k-1];
                r_nq[k]  <= r_nq[k-1];
                r_nr[k]  <= r_nr[k-1];
                r_dz[k]  <= r_dz[k-1];
                r_l[k]   <= r_l[k-1];
                if (k == 1) begin
                    r_p0[k] <= r_p0[k-1] + (((2*WIDTH)'(r_l[k-1])
                        * (2*WIDTH)'(r_b[k-1][WIDTH-1:HW])) << HW);
                end else begin
                    r_p0[k] <= r_p0[k-1];
                end
                if (r_cls[k-1] == T_CLS_DIV) begin
                    if (!df[WIDTH]) begin
                        r_rm[k] <= df[WIDTH-1:0];
                        r_a[k]  <= {r_a[k-1][WIDTH-2:0], 1'b1};
                    end else begin
                        r_rm[k] <= tr[WIDTH-1:0];
                        r_a[k]  <= {r_a[k-1][WIDTH-2:0], 1'b0};
                    end
                end else begin
                    r_rm[k] <= r_rm[k-1];
                    r_a[k]  <= r_a[k-1];
                end
            end
            // final stage passes values on; sign fixup and result select load r_res
            r_cls[NS-1] <= r_cls[NS-2];
            r_md[NS-1]  <= r_md[NS-2];
            r_b[NS-1]   <= r_b[NS-2];
            r_nq[NS-1]  <= r_nq[NS-2];
            r_nr[NS-1]  <= r_nr[NS-2];
            r_dz[NS-1]  <= r_dz[NS-2];
            r_l[NS-1]   <= r_l[NS-2];
            r_p0[NS-1]  <= r_p0[NS-2];
            r_rm[NS-1]  <= r_rm[NS-2];
            r_a[NS-1]   <= r_a[NS-2];
            unique case (r_cls[NS-1])
                T_CLS_MUL: r_res <= r_p0[NS-1][WIDTH-1:0];
                T_CLS_DIV: begin
                    if (r_md[NS-1] == OP_DIVS || r_md[NS-1] == OP_DIVU) begin
                        r_res <= r_dz[NS-1] ? '1
                            : (r_nq[NS-1] ? -r_a[NS-1] : r_a[NS-1]);
                    end else begin
                        r_res <= r_dz[NS-1] ? r_l[NS-1]
                            : (r_nr[NS-1] ? -r_rm[NS-1] : r_rm[NS-1]);
                    end
                end
                default: r_res <= r_a[NS-1];
            endcase
        end
    end

    `IA_ASSERT_NXT(a_b_hold, i_clk, i_rst_n, r_ov && !i_ready, r_ov && $stable(r_res))
    `IA_ASSERT_NXT(a_b_flow, i_clk, i_rst_n, adv && r_v[NS-1], r_ov)
    `IA_ASSERT_NXT(a_b_stall, i_clk, i_rst_n, !adv, $stable(r_v[0]))
endmodule
`default_nettype wire

### rtl/integer_alu_32.sv
// top level of the pipelined 32-bit integer alu
// usage:
//   input channel: drive i_mode, i_left, i_right with i_push; a beat is taken
//     at a rising edge where i_push is high and o_full is low
//   result channel: o_result holds the oldest result while o_empty is low;
//     a beat leaves at a rising edge where i_pop is high
//   order: every operation rides through the one-bit-per-stage divide
//     pipeline in the back end, so results stay in order
//   throughput: one beat per cycle while the result side keeps popping
//   front end classifies and computes add, logic, shift and compare;
//     a small fifo lets it keep accepting while the back end stalls
//   multiply uses two registered half-width partial products
//   divide by zero gives all ones quotient and the dividend as remainder;
//     minimum over minus one wraps to the minimum with zero remainder
//   reset (i_rst_n low, synchronous) empties every stage; no item survives
//   when i_pop stays low the back end freezes once a result waits, the
//     fifo fills, then o_full rises; nothing is dropped
`default_nettype none
module integer_alu_32 #(
    parameter int WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    output logic                             o_full,
    input  wire logic [ia32_pkg::ModeW-1:0]  i_mode,
    input  wire logic [WIDTH-1:0]            i_left,
    input  wire logic [WIDTH-1:0]            i_right,
    output logic                             o_empty,
    input  wire logic                        i_pop,
    output logic [WIDTH-1:0]                 o_result
);
    import ia32_pkg::*;

    // queue entry: class, mode, operands, simple result
    localparam int QW = 2 + ModeW + 3 * WIDTH;

    logic             f_valid, f_ready, f_rdy_in;
    t_cls             f_cls;
    logic [ModeW-1:0] f_mode;
    logic [WIDTH-1:0] f_left, f_right, f_simple;
    logic             q_valid, q_ready;
    logic [QW-1:0]    q_data;
    t_cls             q_cls;
    logic             b_valid;

    assign o_full = !f_rdy_in;

    ia32_front #(.WIDTH(WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_push), .o_ready(f_rdy_in),
        .i_mode(i_mode), .i_left(i_left), .i_right(i_right),
        .o_valid(f_valid), .i_ready(f_ready),
        .o_cls(f_cls), .o_mode(f_mode), .o_left(f_left),
        .o_right(f_right), .o_simple(f_simple)
    );

    ia32_queue #(.DW(QW), .DEPTH(4)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready),
        .i_data({f_cls, f_mode, f_left, f_right, f_simple}),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_data)
    );

    assign q_cls = t_cls'(q_data[QW-1 -: 2]);

    ia32_back #(.WIDTH(WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready),
        .i_cls(q_cls),
        .i_mode(q_data[QW-3 -: ModeW]),
        .i_left(q_data[3*WIDTH-1 -: WIDTH]),
        .i_right(q_data[2*WIDTH-1 -: WIDTH]),
        .i_simple(q_data[WIDTH-1:0]),
        .o_valid(b_valid), .i_ready(i_pop),
        .o_result(o_result)
    );

    assign o_empty = !b_valid;
endmodule
`default_nettype wire
